// ===== rtl/core/ipbd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipbd_pkg: shared types and constants of the box-filter image pyramid
// Field widths, port widths, register indexes and the per-cell link types.
// ----------------------------------------------------------------------------
package ipbd_pkg;

  localparam int PIX_W       = 8;   // pixel value
  localparam int PAIR_W      = 9;   // sum of two pixels
  localparam int SUM_W       = 10;  // sum of four pixels
  localparam int POS_W       = 10;  // column and row of a result
  localparam int LVL_W       = 3;   // level field of a result
  localparam int CNT_W       = 3;   // results carried by one slot
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_LEVEL_W = 3;
  localparam int CFG_SIZE_W  = 12;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 4;

  // Slots of finished results that wait for the output port.
  localparam int SLOT_DEPTH = 4;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_LEVELS = 5;

  localparam logic [CFG_LEVEL_W-1:0] RST_LEVEL_COUNT  = 3'd4;
  localparam logic [CFG_SIZE_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_SIZE_W-1:0]  RST_FRAME_HEIGHT = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_COUNT  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_idx_t;

  // One produced pyramid pixel.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             done;
  } res_t;

  // Control that every cell of the chain sees.
  typedef struct packed {
    logic adv;      // the whole chain moves one step
    logic restart;  // frame restart after a register write
  } ctl_t;

  // Slot header handed from one cell to the next.
  typedef struct packed {
    logic             vld;  // slot holds an accepted input word
    logic             hit;  // a pixel arrives at the receiving level
    logic [CNT_W-1:0] cnt;  // results gathered so far
  } slot_t;

endpackage

// ===== rtl/core/image_pyramid_box_downsampler.sv =====
// ----------------------------------------------------------------------------
// image_pyramid_box_downsampler: streaming 2x2 box-filter image pyramid
// Builds pyramid levels 1 and up from a raster stream of level-zero pixels.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents (lowest bit first)
//  -------   ---------  ------------------------------------------------------
//  s_axis    in         tdata: pixel_in[7:0]
//  m_axis    out        tdata: pixel_out[7:0], column[17:8], row[27:18], zero
//                       tuser: level[2:0], level_done[3]; tlast: last_of_run
//  cfg       in         write enable, register index, write data
//
//  The block takes one pixel word per cycle. Every word enters a chain of
//  MAX_LEVELS cells, one per level, and is registered in each cell in turn
//  before its results reach the result queue. Results leave one word per
//  cycle while m_axis_tready is high, lowest level first. The chain, and with
//  it s_axis_tready, holds only while the queue is full with SLOT_DEPTH
//  slots. Reset is synchronous and needs no clearing pass: a line store
//  entry is always written in an even block row before it is read.
//
module image_pyramid_box_downsampler import ipbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic                   clk,
  input  logic                   rst,
  // Level-zero pixel words.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pixel_in
  // Pyramid pixel words.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_out, column, row
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // level, level_done
  output logic                   m_axis_tlast,   // last result of one input
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NRES = MAX_LEVELS - 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int LW   = $clog2(MAX_LEVELS + 1);

  // Configuration registers.
  logic [CFG_LEVEL_W-1:0] level_count;
  logic [CFG_SIZE_W-1:0]  frame_width;
  logic [CFG_SIZE_W-1:0]  frame_height;
  logic                   cfg_restart;

  // Effective settings after saturation to the supported range.
  logic [LW-1:0]         levels_eff;
  logic [WW-1:0]         width_eff;
  logic [HW-1:0]         height_eff;
  logic [MAX_LEVELS-1:0] lvl_en;

  ctl_t ctl;
  logic q_full;

  // Links between cells; link k feeds cell k.
  slot_t            link_slot [MAX_LEVELS+1];
  logic [PIX_W-1:0] link_pix  [MAX_LEVELS+1];
  res_t [NRES-1:0]  link_res  [MAX_LEVELS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count  <= RST_LEVEL_COUNT;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_COUNT:  level_count  <= CFG_LEVEL_W'(cfg_data);
        REG_FRAME_WIDTH:  frame_width  <= CFG_SIZE_W'(cfg_data);
        REG_FRAME_HEIGHT: frame_height <= CFG_SIZE_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Any write to a defined register starts a new frame on every level.
  always_comb begin
    case (cfg_index)
      REG_LEVEL_COUNT, REG_FRAME_WIDTH, REG_FRAME_HEIGHT: cfg_restart = cfg_we;
      default: cfg_restart = 1'b0;
    endcase
  end

  // A level count of zero acts as one, a count above the chain acts as
  // the full chain; sizes saturate to two and to the largest frame.
  always_comb begin
    if (level_count == '0) begin
      levels_eff = LW'(1);
    end else if (32'(level_count) > MAX_LEVELS) begin
      levels_eff = LW'(MAX_LEVELS);
    end else begin
      levels_eff = LW'(level_count);
    end

    if (32'(frame_width) < 2) begin
      width_eff = WW'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(frame_width);
    end

    if (32'(frame_height) < 2) begin
      height_eff = HW'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(frame_height);
    end
  end

  // The chain moves whenever the result queue can take a slot.
  assign ctl           = '{adv: !q_full, restart: cfg_restart};
  assign s_axis_tready = ctl.adv;

  // Every level-zero word is a pixel for level zero.
  assign link_slot[0] = '{vld: s_axis_tvalid, hit: 1'b1, cnt: '0};
  assign link_pix[0]  = PIX_W'(s_axis_tdata);
  assign link_res[0]  = '0;

  generate
    for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
      // Cell k only forms blocks when level k+1, which it feeds, is enabled.
      assign lvl_en[k] = 32'(k + 1) < 32'(levels_eff);

      ipbd_cell #(
        .K          (k),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .NRES       (NRES)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .prod_en  (lvl_en[k]),
        .width    (width_eff >> k),
        .height   (height_eff >> k),
        .in_slot  (link_slot[k]),
        .in_pix   (link_pix[k]),
        .in_res   (link_res[k]),
        .out_slot (link_slot[k+1]),
        .out_pix  (link_pix[k+1]),
        .out_res  (link_res[k+1])
      );
    end
  endgenerate

  // Only slots that carry at least one result go into the queue.
  ipbd_out #(
    .NRES (NRES)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (ctl.adv && link_slot[MAX_LEVELS].vld &&
                    (link_slot[MAX_LEVELS].cnt != '0)),
    .push_res      (link_res[MAX_LEVELS]),
    .push_cnt      (link_slot[MAX_LEVELS].cnt),
    .full          (q_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/core/ipbd_cell.sv =====
// ----------------------------------------------------------------------------
// ipbd_cell: one pyramid level of the cell chain
// Keeps the level's position counters, held left pixel and line store of
// upper-row pair sums, and hands block results to the next level.
// ----------------------------------------------------------------------------
module ipbd_cell import ipbd_pkg::*; #(
  parameter int K          = 0,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int NRES       = DEF_MAX_LEVELS - 1,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  input  logic                  prod_en,
  input  logic [WW-1:0]         width,
  input  logic [HW-1:0]         height,
  input  slot_t                 in_slot,
  input  logic [PIX_W-1:0]      in_pix,
  input  res_t [NRES-1:0]       in_res,
  output slot_t                 out_slot,
  output logic [PIX_W-1:0]      out_pix,
  output res_t [NRES-1:0]       out_res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int MD = ((MAX_WIDTH >> (K + 1)) > 0) ? (MAX_WIDTH >> (K + 1)) : 1;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(K);

  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [PIX_W-1:0]  held;
  logic [PAIR_W-1:0] mem [MD];
  logic [PAIR_W-1:0] rd;
  logic [PAIR_W-1:0] pair;
  slot_t             slot;
  res_t [NRES-1:0]   res;

  logic              take;
  logic [PAIR_W-1:0] pair_now;
  logic [AW-1:0]     addr;
  logic [WW-1:0]     col_inc;
  logic [HW-1:0]     row_inc;
  logic              col_wrap;
  logic              row_wrap;
  logic [CW-1:0]     col_next;
  logic [RW-1:0]     row_next;
  logic              last_px;
  logic [SUM_W-1:0]  sum;
  res_t [NRES-1:0]   res_next;

  assign take     = ctl.adv && in_slot.vld && in_slot.hit;
  assign pair_now = {1'b0, held} + {1'b0, in_pix};
  assign addr     = AW'(col >> 1);
  assign col_inc  = WW'(col) + WW'(1);
  assign row_inc  = HW'(row) + HW'(1);
  assign col_wrap = col_inc >= width;
  assign row_wrap = row_inc >= height;
  assign col_next = col_wrap ? '0 : CW'(col_inc);
  assign row_next = col_wrap ? (row_wrap ? '0 : RW'(row_inc)) : row;
  assign last_px  = (col_inc == width) && (row_inc == height);

  // A cell above level zero records the pixel it receives as a result.
  generate
    if (K > 0) begin : g_rec
      always_comb begin
        res_next = in_res;
        if (in_slot.hit) begin
          res_next[K-1] = '{pix: in_pix, col: POS_W'(col), row: POS_W'(row),
                            done: last_px};
        end
      end
    end else begin : g_pass
      assign res_next = in_res;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      col  <= '0;
      row  <= '0;
      held <= '0;
    end else if (take) begin
      if (!col[0]) begin
        held <= in_pix;
      end
      col <= col_next;
      row <= row_next;
    end
  end

  // Even block rows store the pair sum, odd block rows read it back.
  always_ff @(posedge clk) begin
    if (take && col[0]) begin
      if (!row[0]) begin
        mem[addr] <= pair_now;
      end
      rd <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (ctl.adv) begin
      slot.vld <= in_slot.vld;
      slot.hit <= in_slot.vld && in_slot.hit && prod_en && col[0] && row[0];
      slot.cnt <= ((K > 0) && in_slot.hit) ? MY_CNT : in_slot.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      pair <= pair_now;
      res  <= res_next;
    end
  end

  assign sum      = {1'b0, rd} + {1'b0, pair};
  assign out_pix  = sum[SUM_W-1:2];
  assign out_slot = slot;
  assign out_res  = res;

endmodule

// ===== rtl/core/ipbd_out.sv =====
// ----------------------------------------------------------------------------
// ipbd_out: result slot queue and output serializer
// Holds finished slots of one to several results and sends their results
// one word per cycle while m_axis_tready is high; tlast marks a slot's last.
// ----------------------------------------------------------------------------
module ipbd_out import ipbd_pkg::*; #(
  parameter int NRES = DEF_MAX_LEVELS - 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  res_t [NRES-1:0]        push_res,
  input  logic [CNT_W-1:0]       push_cnt,
  output logic                   full,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int PW = $clog2(SLOT_DEPTH);
  localparam int SW = (NRES > 1) ? $clog2(NRES) : 1;

  res_t [NRES-1:0]  q_res [SLOT_DEPTH];
  logic [CNT_W-1:0] q_cnt [SLOT_DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [PW:0]      fill;
  logic [SW-1:0]    sidx;

  res_t             head;
  logic             step;
  logic             pop;
  logic [LVL_W-1:0] level;

  assign head  = q_res[rp][sidx];
  assign level = LVL_W'(sidx) + LVL_W'(1);

  assign full          = fill == (PW + 1)'(SLOT_DEPTH);
  assign m_axis_tvalid = fill != '0;
  assign m_axis_tlast  = (CNT_W'(sidx) + CNT_W'(1)) == q_cnt[rp];
  assign m_axis_tdata  = OUT_TDATA_W'({head.row, head.col, head.pix});
  assign m_axis_tuser  = {head.done, level};

  assign step = m_axis_tvalid && m_axis_tready;
  assign pop  = step && m_axis_tlast;

  always_ff @(posedge clk) begin
    if (push) begin
      q_res[wp] <= push_res;
      q_cnt[wp] <= push_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
      sidx <= '0;
    end else begin
      if (push) begin
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW + 1)'(1);
      end
      if (step) begin
        sidx <= m_axis_tlast ? '0 : sidx + SW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ipbd_checker.sv =====
// ----------------------------------------------------------------------------
// ipbd_checker: port-level checks of the box-filter image pyramid
// Watches the stream ports and flags breaks of handshake or result order.
// ----------------------------------------------------------------------------
module ipbd_checker import ipbd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                   m_axis_tlast
);

  // Level zero is never sent out.
  a_level_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[LVL_W-1:0] != '0))
    else $error("result word carries level zero");

  // A stalled word keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled result word changed");

  // Results of one input come out back to back, one level higher each.
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid &&
       (m_axis_tuser[LVL_W-1:0] == $past(m_axis_tuser[LVL_W-1:0]) + 3'd1)))
    else $error("result run broken or out of level order");

  // Input is held back only while results wait at the output.
  a_hold_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input held back with no result pending");

  // A pixel word that waits at the input keeps its value until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && !s_axis_tready) |=>
      (s_axis_tvalid && $stable(s_axis_tdata)))
    else $error("stalled input word changed");

endmodule

bind image_pyramid_box_downsampler ipbd_checker u_ipbd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
